// ----- rtl/core/rse_pkg.sv -----
// Shared types, constants and the GF(2^m) multiply for the Reed-Solomon encoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package rse_pkg;

    localparam int SYM_W          = 8;
    localparam int NPAR_W         = 7;
    localparam int CNT_W          = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 9;
    localparam int MAX_PARITY_DEF = 32;
    localparam int MAX_SYMB_DEF   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROOT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_CNT  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_BAD_POLY = 2'd2;

    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [NPAR_W-1:0] t_npar;
    typedef logic [1:0]        t_status;

    typedef struct packed {
        logic  built;
        logic  ok;
        t_sym  mask;
        t_sym  taps;
        t_npar npar;
    } t_field;

    typedef struct packed {
        logic    valid;
        t_status stat;
        t_npar   count;
    } t_load;

    // MSB-first shift-and-add multiply, reduced at the current symbol width
    function automatic t_sym gf_mul(t_sym a, t_sym b, t_sym taps, t_sym mask);
        t_sym acc;
        t_sym hi;
        acc = '0;
        hi  = mask ^ (mask >> 1);
        for (int k = SYM_W - 1; k >= 0; k--) begin
            acc = ((acc << 1) ^ (((acc & hi) != '0) ? taps : '0)) & mask;
            if (b[k]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/core/rse_gen.sv -----
// Configuration registers and the sequencer that checks the field polynomial
// and builds the generator polynomial. Depends on rse_pkg.
`timescale 1ns / 1ps
module rse_gen
    import rse_pkg::*;
#(
    parameter int MAX_PARITY      = MAX_PARITY_DEF,
    parameter int MAX_SYMBOL_BITS = MAX_SYMB_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output t_field                      o_field,
    output logic [MAX_PARITY:0][SYM_W-1:0] o_coef
);

    localparam logic [1:0] GS_FIELD = 2'd0;
    localparam logic [1:0] GS_POW   = 2'd1;
    localparam logic [1:0] GS_GEN   = 2'd2;
    localparam logic [1:0] GS_DONE  = 2'd3;

    logic [3:0]            r_symbol_bits;
    logic [8:0]            r_field_poly;
    logic [7:0]            r_first_root;
    logic [7:0]            r_root_step;
    logic [5:0]            r_parity_cnt;
    logic [1:0]            r_state;
    logic [CNT_W-1:0]      r_i;
    t_npar                 r_t;
    t_sym                  r_sr;
    t_sym                  r_as;
    t_sym                  r_r;
    logic                  r_ok;
    logic [MAX_PARITY:0][SYM_W-1:0] r_rev;

    logic [3:0] mbits;
    t_sym       mask;
    t_sym       taps;
    t_npar      npar;
    logic       known_idx;

    always_comb begin
        if (r_symbol_bits < 4'd3) begin
            mbits = 4'd3;
        end else if (r_symbol_bits > 4'(MAX_SYMBOL_BITS)) begin
            mbits = 4'(MAX_SYMBOL_BITS);
        end else begin
            mbits = r_symbol_bits;
        end
        mask = SYM_W'((9'd1 << mbits) - 9'd1);
        taps = r_field_poly[SYM_W-1:0] & mask;
        if (r_parity_cnt == 6'd0) begin
            npar = NPAR_W'(1);
        end else if (NPAR_W'(r_parity_cnt) > NPAR_W'(MAX_PARITY)) begin
            npar = NPAR_W'(MAX_PARITY);
        end else begin
            npar = NPAR_W'(r_parity_cnt);
        end
        known_idx = (i_cfg_index == REG_SYMBOL_BITS) || (i_cfg_index == REG_FIELD_POLY) ||
                    (i_cfg_index == REG_FIRST_ROOT) || (i_cfg_index == REG_ROOT_STEP) ||
                    (i_cfg_index == REG_PARITY_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_bits <= 4'd8;
            r_field_poly  <= 9'd285;
            r_first_root  <= 8'd0;
            r_root_step   <= 8'd1;
            r_parity_cnt  <= 6'd32;
            r_state       <= GS_FIELD;
            r_i           <= '0;
            r_sr          <= SYM_W'(1);
            r_ok          <= 1'b1;
        end else if (i_cfg_we && known_idx) begin
            case (i_cfg_index)
                REG_SYMBOL_BITS: r_symbol_bits <= i_cfg_data[3:0];
                REG_FIELD_POLY:  r_field_poly  <= i_cfg_data;
                REG_FIRST_ROOT:  r_first_root  <= i_cfg_data[7:0];
                REG_ROOT_STEP:   r_root_step   <= i_cfg_data[7:0];
                REG_PARITY_CNT:  r_parity_cnt  <= i_cfg_data[5:0];
                default: ;
            endcase
            r_state <= GS_FIELD;
            r_i     <= '0;
            r_sr    <= SYM_W'(1);
            r_ok    <= 1'b1;
        end else begin
            case (r_state)
                GS_FIELD: begin
                    if (r_i < CNT_W'(mask)) begin
                        if (r_sr == '0 || (r_i != '0 && r_sr == SYM_W'(1))) begin
                            r_ok <= 1'b0;
                        end
                    end else if (r_i == CNT_W'(mask) && r_sr != SYM_W'(1)) begin
                        r_ok <= 1'b0;
                    end
                    if (r_i == r_root_step) begin
                        r_as <= r_sr;
                    end
                    r_sr <= gf_mul(r_sr, SYM_W'(2), taps, mask);
                    if (r_i == '1) begin
                        r_state <= GS_POW;
                        r_i     <= '0;
                        r_r     <= SYM_W'(1);
                    end else begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                GS_POW: begin
                    if (r_i == r_first_root) begin
                        r_state <= GS_GEN;
                        r_t     <= '0;
                        r_rev   <= ((MAX_PARITY + 1) * SYM_W)'(1);
                    end else begin
                        r_r <= gf_mul(r_r, r_as, taps, mask);
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                GS_GEN: begin
                    if (r_t == npar || !r_ok) begin
                        r_state <= GS_DONE;
                    end else begin
                        // multiply by (x + r), leading coefficient first
                        for (int k = 1; k <= MAX_PARITY; k++) begin
                            r_rev[k] <= r_rev[k] ^ gf_mul(r_r, r_rev[k-1], taps, mask);
                        end
                        r_r <= gf_mul(r_r, r_as, taps, mask);
                        r_t <= r_t + NPAR_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_field.built = (r_state == GS_DONE);
    assign o_field.ok    = r_ok;
    assign o_field.mask  = mask;
    assign o_field.taps  = taps;
    assign o_field.npar  = npar;
    assign o_coef        = r_rev;

endmodule

// ----- rtl/core/rse_lfsr.sv -----
// Parity LFSR with block length tracking; one symbol per cycle while i_accept is high.
// Depends on rse_pkg and the field description from rse_gen.
`timescale 1ns / 1ps
module rse_lfsr
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  t_sym                            i_data,
    input  logic                            i_last,
    input  t_field                          i_field,
    input  logic [MAX_PARITY:0][SYM_W-1:0]  i_coef,
    output t_load                           o_load,
    output logic [MAX_PARITY-1:0][SYM_W-1:0] o_parity
);

    logic [MAX_PARITY-1:0][SYM_W-1:0] r_par;
    logic [MAX_PARITY-1:0][SYM_W-1:0] n_par;
    logic [CNT_W-1:0]                 r_cnt;
    logic [CNT_W-1:0]                 n_cnt;
    logic                             r_too_long;
    logic                             n_too_long;
    t_sym                             fb;
    t_sym                             nxt;
    t_sym                             ce;

    always_comb begin
        fb = (i_data & i_field.mask) ^ r_par[0];
        for (int j = 0; j < MAX_PARITY; j++) begin
            nxt = (j + 1 < MAX_PARITY) ? r_par[(j + 1) % MAX_PARITY] : '0;
            ce  = (i_coef[j+1] == '0) ? SYM_W'(1) : i_coef[j+1];
            n_par[j] = (NPAR_W'(j) < i_field.npar) ? (nxt ^ gf_mul(fb, ce, i_field.taps,
                                                      i_field.mask)) : '0;
        end
        n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + CNT_W'(1);
        n_too_long = r_too_long || ({1'b0, i_field.npar} >= (NPAR_W+1)'(i_field.mask)) ||
                     ((CNT_W+1)'(n_cnt) + (CNT_W+1)'(i_field.npar) > (CNT_W+1)'(i_field.mask));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || !i_field.built) begin
            r_par      <= '0;
            r_cnt      <= '0;
            r_too_long <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_par      <= '0;
                r_cnt      <= '0;
                r_too_long <= 1'b0;
            end else begin
                if (i_field.ok && !n_too_long) begin
                    r_par <= n_par;
                end
                r_cnt      <= n_cnt;
                r_too_long <= n_too_long;
            end
        end
    end

    always_comb begin
        o_load.valid = i_accept && i_last;
        if (!i_field.ok) begin
            o_load.stat  = ST_BAD_POLY;
            o_load.count = NPAR_W'(1);
        end else if (n_too_long) begin
            o_load.stat  = ST_TOO_LONG;
            o_load.count = NPAR_W'(1);
        end else begin
            o_load.stat  = ST_OK;
            o_load.count = i_field.npar;
        end
    end

    assign o_parity = n_par;

endmodule

// ----- rtl/core/rse_obuf.sv -----
// Result buffer: holds the parity of one finished block and shifts it out.
// Depends on rse_pkg.
`timescale 1ns / 1ps
module rse_obuf
    import rse_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_load                            i_load,
    input  logic [MAX_PARITY-1:0][SYM_W-1:0] i_parity,
    input  logic                             i_ready,
    output logic                             o_valid,
    output logic                             o_drain,
    output t_sym                             o_symbol,
    output logic                             o_last,
    output t_status                          o_status
);

    logic [MAX_PARITY-1:0][SYM_W-1:0] r_buf;
    t_npar                            r_cnt;
    t_status                          r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load.valid) begin
            r_cnt  <= i_load.count;
            r_stat <= i_load.stat;
            r_buf  <= (i_load.stat == ST_OK) ? i_parity : '0;
        end else if (o_valid && i_ready) begin
            r_cnt <= r_cnt - NPAR_W'(1);
            for (int j = 0; j + 1 < MAX_PARITY; j++) begin
                r_buf[j] <= r_buf[j+1];
            end
        end
    end

    assign o_valid  = (r_cnt != '0);
    assign o_drain  = (r_cnt == '0) || (r_cnt == NPAR_W'(1) && i_ready);
    assign o_symbol = r_buf[0];
    assign o_last   = (r_cnt == NPAR_W'(1));
    assign o_status = r_stat;

endmodule

// ----- rtl/core/reed_solomon_encoder.sv -----
// Top level of the systematic Reed-Solomon encoder over GF(2^m).
// Depends on rse_pkg, rse_gen, rse_lfsr and rse_obuf.
`timescale 1ns / 1ps
// Data symbols enter one per cycle while o_in_ready is high and are encoded at one
// transaction per clock by the parity LFSR. After reset and after every configuration write
// the block rebuilds its field and generator polynomial and holds o_in_ready low while it
// walks the whole field, steps the root power up to first_root and multiplies in one
// generator factor per step up to parity_count (with a non-primitive polynomial the
// generator multiply ends at once). On the symbol marked last, the block parity is
// copied into a result buffer that drains one symbol per cycle while i_out_ready is high
// (parity_count results, or one error result); data of the next block keeps flowing
// meanwhile, and only a second last symbol waits until the buffer has emptied.
// Configuration must be written only while idle; the block itself does not enforce it.
module reed_solomon_encoder
    import rse_pkg::*;
#(
    parameter int MAX_PARITY      = MAX_PARITY_DEF,
    parameter int MAX_SYMBOL_BITS = MAX_SYMB_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SYM_W-1:0]      i_data_symbol,
    input  logic                  i_last_symbol,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SYM_W-1:0]      o_parity_symbol,
    output logic                  o_parity_last,
    output logic [1:0]            o_status
);

    t_field                           field;
    logic [MAX_PARITY:0][SYM_W-1:0]   coef;
    t_load                            load;
    logic [MAX_PARITY-1:0][SYM_W-1:0] parity;
    logic                             drain;
    logic                             accept;

    rse_gen #(
        .MAX_PARITY      (MAX_PARITY),
        .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
    ) u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_field     (field),
        .o_coef      (coef)
    );

    // hold a last symbol back while the previous block's parity still drains
    assign o_in_ready = field.built && (!i_last_symbol || drain);
    assign accept     = i_in_valid && o_in_ready;

    rse_lfsr #(
        .MAX_PARITY (MAX_PARITY)
    ) u_lfsr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data_symbol),
        .i_last   (i_last_symbol),
        .i_field  (field),
        .i_coef   (coef),
        .o_load   (load),
        .o_parity (parity)
    );

    rse_obuf #(
        .MAX_PARITY (MAX_PARITY)
    ) u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_parity (parity),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_drain  (drain),
        .o_symbol (o_parity_symbol),
        .o_last   (o_parity_last),
        .o_status (o_status)
    );

endmodule

// ----- verif/rse_parity_checker.sv -----
// Transaction checker for the Reed-Solomon encoder: mirrors the configuration,
// predicts parity and status for each data transaction and compares results.
// Depends on rse_pkg for widths, register indexes and status codes.
`timescale 1ns / 1ps
module rse_parity_checker
    import rse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SYM_W-1:0]      i_data_symbol,
    input  logic                  i_last_symbol,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [SYM_W-1:0]      i_parity_symbol,
    input  logic                  i_parity_last,
    input  logic [1:0]            i_status,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        t_sym    sym;
        logic    last;
        t_status stat;
    } t_parity_exp;

    t_parity_exp parity_q[$];

    int   cfg_m, cfg_poly, cfg_root0, cfg_step, cfg_npar;
    int   mbits, nn, npar;
    int   antilog[256];
    int   logt[256];
    int   gen_log[33];
    int   lfsr[32];
    int   sym_cnt;
    logic overlong;
    logic field_good;
    int   fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = parity_q.size();

    task automatic clear_block();
        for (int j = 0; j < 32; j++) lfsr[j] = 0;
        sym_cnt  = 0;
        overlong = 1'b0;
    endtask

    // Build field tables and generator log coefficients from the mirrored registers
    task automatic build_field();
        int sr, root, step;
        int gp[33];
        mbits = (cfg_m < 3) ? 3 : (cfg_m > 8) ? 8 : cfg_m;
        nn    = (1 << mbits) - 1;
        npar  = (cfg_npar < 1) ? 1 : (cfg_npar > 32) ? 32 : cfg_npar;
        for (int i = 0; i < 256; i++) begin
            antilog[i] = 0;
            logt[i]    = 0;
        end
        logt[0]    = nn;
        field_good = 1'b1;
        sr = 1;
        for (int i = 0; i < nn; i++) begin
            if (sr == 0 || (i > 0 && sr == 1)) field_good = 1'b0;
            logt[sr & nn] = i;
            antilog[i]    = sr;
            sr = sr << 1;
            if (sr & (1 << mbits)) sr = sr ^ cfg_poly;
            sr = sr & nn;
        end
        if (sr != 1) field_good = 1'b0;
        for (int i = 0; i < 33; i++) gen_log[i] = 0;
        if (field_good) begin
            step  = cfg_step % nn;
            root  = ((cfg_root0 % nn) * step) % nn;
            gp[0] = 1;
            for (int i = 0; i < npar; i++) begin
                gp[i+1] = 1;
                for (int j = i; j > 0; j--) begin
                    if (gp[j] != 0) gp[j] = gp[j-1] ^ antilog[(logt[gp[j] & nn] + root) % nn];
                    else gp[j] = gp[j-1];
                end
                gp[0] = antilog[(logt[gp[0] & nn] + root) % nn];
                root  = (root + step) % nn;
            end
            for (int i = 0; i <= npar; i++) gen_log[i] = logt[gp[i] & nn];
        end
    endtask

    // Advance the LFSR by one symbol and queue the results a last symbol causes
    task automatic encode_symbol(input int data, input logic last);
        int d, fb;
        t_parity_exp e;
        d = data & nn;
        if (sym_cnt < 255) sym_cnt++;
        if (npar >= nn || sym_cnt > nn - npar) overlong = 1'b1;
        if (field_good && !overlong) begin
            fb = logt[(d ^ lfsr[0]) & nn];
            if (fb != nn) begin
                for (int j = 1; j < npar; j++)
                    lfsr[j] ^= antilog[(fb + gen_log[npar-j]) % nn];
            end
            for (int j = 0; j + 1 < npar; j++) lfsr[j] = lfsr[j+1];
            lfsr[npar-1] = (fb != nn) ? antilog[(fb + gen_log[0]) % nn] : 0;
        end
        if (last) begin
            if (!field_good || overlong) begin
                e.sym  = '0;
                e.last = 1'b1;
                e.stat = field_good ? ST_TOO_LONG : ST_BAD_POLY;
                parity_q.push_back(e);
            end else begin
                for (int j = 0; j < npar; j++) begin
                    e.sym  = t_sym'(lfsr[j]);
                    e.last = (j + 1 == npar);
                    e.stat = ST_OK;
                    parity_q.push_back(e);
                end
            end
            clear_block();
        end
    endtask

    always @(posedge i_clk) begin
        t_parity_exp e;
        if (!i_rst_n) begin
            cfg_m     = 8;
            cfg_poly  = 285;
            cfg_root0 = 0;
            cfg_step  = 1;
            cfg_npar  = 32;
            build_field();
            clear_block();
            parity_q.delete();
            fail_count = 0;
        end else begin
            // Compare the result transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (parity_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: sym %0h last %0b status %0d",
                                 i_parity_symbol, i_parity_last, i_status);
                end else begin
                    e = parity_q.pop_front();
                    if (e.sym !== i_parity_symbol || e.last !== i_parity_last ||
                        e.stat !== i_status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp sym %0h last %0b status %0d, got %0h %0b %0d",
                                     e.sym, e.last, e.stat,
                                     i_parity_symbol, i_parity_last, i_status);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SYMBOL_BITS: cfg_m     = i_cfg_data & 9'h00F;
                    REG_FIELD_POLY:  cfg_poly  = i_cfg_data & 9'h1FF;
                    REG_FIRST_ROOT:  cfg_root0 = i_cfg_data & 9'h0FF;
                    REG_ROOT_STEP:   cfg_step  = i_cfg_data & 9'h0FF;
                    REG_PARITY_CNT:  cfg_npar  = i_cfg_data & 9'h03F;
                    default: ;
                endcase
                if (i_cfg_index <= REG_PARITY_CNT) begin
                    build_field();
                    clear_block();
                end
            end
            if (i_in_valid && i_in_ready) encode_symbol(i_data_symbol, i_last_symbol);
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Stimulus top for the Reed-Solomon encoder: directed corner blocks, then random phases.
// Depends on rse_pkg, reed_solomon_encoder and rse_parity_checker.
`timescale 1ns / 1ps
module tb_top;
    import rse_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [SYM_W-1:0]      i_data_symbol = '0;
    logic                  i_last_symbol = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SYM_W-1:0]      o_parity_symbol;
    logic                  o_parity_last;
    logic [1:0]            o_status;

    int fail_count;
    int pending;
    int sent_count;
    int idle_cycles;
    int ready_hold;
    logic no_gaps;

    always #2 i_clk = ~i_clk;

    reed_solomon_encoder DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_ready, .i_data_symbol, .i_last_symbol,
        .o_out_valid, .i_out_ready, .o_parity_symbol, .o_parity_last, .o_status
    );

    rse_parity_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_data_symbol, .i_last_symbol,
        .i_out_valid(o_out_valid), .i_out_ready, .i_parity_symbol(o_parity_symbol),
        .i_parity_last(o_parity_last), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result side: hold ready for a random stretch, mostly high, with rare long stalls
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    begin i_out_ready <= 1'b0; ready_hold <= $urandom_range(0, 3); end
                2:       begin i_out_ready <= 1'b0; ready_hold <= $urandom_range(10, 30); end
                default: begin i_out_ready <= 1'b1; ready_hold <= $urandom_range(0, 20); end
            endcase
        end
    end

    // Watchdog: drop the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Pick an idle gap after a data transaction; none during burst phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one data symbol, hold it until accepted, then idle for a random gap
    task automatic send_symbol(input logic [7:0] data, input logic last);
        int gap;
        i_in_valid    <= 1'b1;
        i_data_symbol <= data;
        i_last_symbol <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted result has been drained
    task automatic drain_results();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write one register once the block is idle, then wait out the rebuild
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        drain_results();
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input int m, input int poly, input int root0, input int step,
                              input int npar);
        write_reg(REG_SYMBOL_BITS, m);
        write_reg(REG_FIELD_POLY, poly);
        write_reg(REG_FIRST_ROOT, root0);
        write_reg(REG_ROOT_STEP, step);
        write_reg(REG_PARITY_CNT, npar);
    endtask

    task automatic send_block(input int len);
        for (int k = 0; k < len; k++) send_symbol(8'($urandom_range(0, 255)), k == len - 1);
    endtask

    initial begin
        int prim[9];
        int m, nn, npar, room, len;
        prim[3] = 'h00B; prim[4] = 'h013; prim[5] = 'h025;
        prim[6] = 'h043; prim[7] = 'h089; prim[8] = 'h11D;
        sent_count  = 0;
        idle_cycles = 0;
        ready_hold  = 0;
        no_gaps     = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);

        // Reset configuration: extreme data values, one-symbol block
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hA5, 1'b1);
        send_symbol(8'h5A, 1'b1);

        // Smallest field, largest first root, zero root step
        set_config(3, prim[3], 255, 0, 2);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h07, 1'b1);
        // Block one symbol too long for the field
        send_block(6);
        // Parity count fills the field: every block is too long
        write_reg(REG_PARITY_CNT, 7);
        send_symbol(8'h01, 1'b1);
        // Out-of-range widths and counts saturate
        set_config(0, prim[3], 1, 255, 0);
        send_block(3);
        set_config(15, prim[8], 0, 1, 63);
        send_block(2);
        // Period shorter than the field: not primitive
        write_reg(REG_FIELD_POLY, 'h11B);
        send_block(2);
        // Zero taps, and an overlong block with a bad polynomial
        set_config(3, 'h008, 0, 1, 2);
        send_block(6);
        // Top bits above m ignored
        write_reg(REG_FIELD_POLY, 'h1F0 | prim[3]);
        send_block(3);

        // Random phases
        while (sent_count < 320) begin
            m = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 8) : $urandom_range(3, 5);
            nn = (1 << m) - 1;
            npar = (nn > 33) ? $urandom_range(1, 32) : $urandom_range(1, nn - 1);
            if ($urandom_range(0, 15) == 0) npar = $urandom_range(nn, 63);
            set_config(m, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : prim[m],
                       $urandom_range(0, 255), $urandom_range(0, 255), npar);
            no_gaps = ($urandom_range(0, 3) == 0);
            room = nn - npar;
            for (int b = 0; b < 4; b++) begin
                if ($urandom_range(0, 5) == 0) drain_results();
                if (room < 1)
                    len = $urandom_range(1, 3);
                else if ($urandom_range(0, 7) == 0)
                    len = room + $urandom_range(1, 3);
                else
                    len = $urandom_range(1, (room > 12) ? 12 : room);
                send_block(len);
            end
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- reed_solomon_encoder.f -----
rtl/core/rse_pkg.sv
rtl/core/rse_gen.sv
rtl/core/rse_lfsr.sv
rtl/core/rse_obuf.sv
rtl/core/reed_solomon_encoder.sv
verif/rse_parity_checker.sv
verif/tb_top.sv
